// ----- sv/jos_pkg.sv -----
// shared types and constants of the josephus ring eliminator
`timescale 1ns / 1ps

package jos_pkg;

    localparam int DEPTH     = 32;
    localparam int DATA_W    = 32;
    localparam int STEP_W    = 16;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int LEFT_W    = 6;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int MOD_CNT_W = $clog2(STEP_W + 1);

    localparam logic [REQ_W-1:0] REQ_APPEND    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ELIMINATE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

    typedef struct packed {
        logic              shift;
        logic              ins;
        logic [IDX_W-1:0]  ins_pos;
        logic [DATA_W-1:0] ins_data;
    } jos_cell_ctrl_t;

endpackage

// ----- sv/jos_cell.sv -----
// one ring cell: holds one value, shifts toward the head or takes an insert
`timescale 1ns / 1ps

module jos_cell
    import jos_pkg::*;
(
    input  logic                 clk,
    input  logic [IDX_W-1:0]     cell_idx,
    input  jos_cell_ctrl_t       ctrl,
    input  logic [DATA_W-1:0]    nbr_value,
    output logic [DATA_W-1:0]    value
);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;

    always_comb
    begin
        priority if (ctrl.ins && (ctrl.ins_pos == cell_idx))
        begin
            value_next = ctrl.ins_data;
        end
        else if (ctrl.shift)
        begin
            value_next = nbr_value;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- sv/jos_mod.sv -----
// iterative remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module jos_mod
    import jos_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [STEP_W-1:0] dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [CNT_W-1:0]  remainder
);

    logic [STEP_W-1:0]    num_reg;
    logic [CNT_W-1:0]     div_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic [CNT_W:0]       rem_shift;
    logic [CNT_W:0]       rem_sub;

    assign rem_shift = {rem_reg, num_reg[STEP_W-1]};
    assign rem_sub   = rem_shift - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= MOD_CNT_W'(STEP_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MOD_CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            num_reg <= {num_reg[STEP_W-2:0], 1'b0};
            // restoring step: no borrow means the divisor fits
            if (!rem_sub[CNT_W])
            begin
                rem_reg <= rem_sub[CNT_W-1:0];
            end
            else
            begin
                rem_reg <= rem_shift[CNT_W-1:0];
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- sv/circular_list_josephus_eliminator.sv -----
// top level: controller and chain of ring cells of the josephus eliminator
//
//  channel   | handshake            | fields
//  ----------+----------------------+---------------------------------------------
//  request   | start, busy          | req_type, item_value, step_count
//  result    | done (strobe)        | status, out_value, entries_left, last_result
//
// append and rejected requests finish in idle, result on the next cycle.
// remove rotates the ring through the head cell once, dropping entries equal to the key.
// eliminate per removal: remainder of (step - 1) by the ring size in jos_mod,
// a handover in S_MODW, then one rotation per skipped entry and one pop.
// reset clears the ring size and control; cell contents are not cleared.
// the receiver cannot stall: done is high for one cycle per result.
`timescale 1ns / 1ps

module circular_list_josephus_eliminator
    import jos_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [REQ_W-1:0]           req_type,
    input  logic signed [DATA_W-1:0]   item_value,
    input  logic [STEP_W-1:0]          step_count,
    output logic                       done,
    output logic [STATUS_W-1:0]        status,
    output logic signed [DATA_W-1:0]   out_value,
    output logic [LEFT_W-1:0]          entries_left,
    output logic                       last_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REMOVE,
        S_MODW,
        S_SKIP
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   size_reg, size_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DATA_W-1:0]  key_reg, key_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0]  out_value_reg, out_value_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic               last_reg, last_next;

    jos_cell_ctrl_t     ctrl;
    logic [DATA_W-1:0]  cell_q [DEPTH];
    logic [DATA_W-1:0]  head;
    logic [CNT_W-1:0]   size_m1;
    logic               mod_start;
    logic [STEP_W-1:0]  mod_dividend;
    logic [CNT_W-1:0]   mod_divisor;
    logic               mod_done;
    logic [CNT_W-1:0]   mod_rem;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_W-1:0] nbr;
            if (gi == DEPTH - 1)
            begin : g_tail
                assign nbr = cell_q[gi];
            end
            else
            begin : g_body
                assign nbr = cell_q[gi + 1];
            end
            jos_cell u_cell (
                .clk       (clk),
                .cell_idx  (IDX_W'(gi)),
                .ctrl      (ctrl),
                .nbr_value (nbr),
                .value     (cell_q[gi])
            );
        end
    endgenerate

    jos_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (mod_divisor),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign head    = cell_q[0];
    assign size_m1 = size_reg - 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        cnt_next       = cnt_reg;
        key_next       = key_reg;
        step_next      = step_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        out_value_next = out_value_reg;
        left_next      = left_reg;
        last_next      = last_reg;
        ctrl.shift     = 1'b0;
        ctrl.ins       = 1'b0;
        ctrl.ins_pos   = size_m1[IDX_W-1:0];
        ctrl.ins_data  = head;
        mod_start      = 1'b0;
        mod_dividend   = step_reg;
        mod_divisor    = size_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    priority if (req_type == REQ_APPEND)
                    begin
                        done_next      = 1'b1;
                        out_value_next = '0;
                        last_next      = 1'b1;
                        if (size_reg >= CNT_W'(DEPTH))
                        begin
                            status_next = ST_FULL;
                            left_next   = size_reg;
                        end
                        else
                        begin
                            ctrl.ins      = 1'b1;
                            ctrl.ins_pos  = size_reg[IDX_W-1:0];
                            ctrl.ins_data = item_value;
                            size_next     = size_reg + 1'b1;
                            status_next   = ST_DONE;
                            left_next     = size_reg + 1'b1;
                        end
                    end
                    else if (req_type == REQ_REMOVE)
                    begin
                        if (size_reg == '0)
                        begin
                            done_next      = 1'b1;
                            status_next    = ST_DONE;
                            out_value_next = '0;
                            left_next      = '0;
                            last_next      = 1'b1;
                        end
                        else
                        begin
                            key_next   = item_value;
                            cnt_next   = size_reg;
                            state_next = S_REMOVE;
                        end
                    end
                    else if ((req_type == REQ_ELIMINATE) && (step_count != '0)
                             && (size_reg != '0))
                    begin
                        step_next    = step_count - 1'b1;
                        mod_start    = 1'b1;
                        mod_dividend = step_count - 1'b1;
                        state_next   = S_MODW;
                    end
                    else
                    begin
                        done_next      = 1'b1;
                        status_next    = ST_NONE;
                        out_value_next = '0;
                        left_next      = size_reg;
                        last_next      = 1'b1;
                    end
                end
            end

            S_REMOVE:
            begin
                // head leaves the chain; kept values go back in at the tail
                ctrl.shift = 1'b1;
                if (head != key_reg)
                begin
                    ctrl.ins = 1'b1;
                end
                else
                begin
                    size_next = size_m1;
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_next      = 1'b1;
                    status_next    = ST_DONE;
                    out_value_next = '0;
                    left_next      = size_next;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_MODW:
            begin
                if (mod_done)
                begin
                    cnt_next   = mod_rem;
                    state_next = S_SKIP;
                end
            end

            S_SKIP:
            begin
                ctrl.shift = 1'b1;
                if (cnt_reg != '0)
                begin
                    ctrl.ins = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    // pop the head: the entry after it becomes the new head
                    size_next      = size_m1;
                    done_next      = 1'b1;
                    status_next    = ST_DONE;
                    out_value_next = head;
                    left_next      = size_m1;
                    last_next      = (size_m1 == '0);
                    if (size_m1 == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mod_start   = 1'b1;
                        mod_divisor = size_m1;
                        state_next  = S_MODW;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= '0;
            cnt_reg       <= '0;
            done_reg      <= 1'b0;
            status_reg    <= ST_DONE;
            out_value_reg <= '0;
            left_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            cnt_reg       <= cnt_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            out_value_reg <= out_value_next;
            left_reg      <= left_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        step_reg <= step_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign out_value    = out_value_reg;
    assign entries_left = LEFT_W'(left_reg);
    assign last_result  = last_reg;

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (last_result == !busy))
        else $error("final result and busy disagree");

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg <= CNT_W'(DEPTH))
        else $error("ring size above depth");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> (size_reg == CNT_W'(DEPTH)))
        else $error("full status with room in the ring");

    a_skip_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SKIP) |-> (cnt_reg < size_reg))
        else $error("skip count not below ring size");

    a_mod_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MODW) && mod_done) |=> (state_reg == S_SKIP))
        else $error("remainder not taken");

endmodule

// ----- tb/tb_top.sv -----
// testbench of the josephus ring eliminator: directed and random requests checked against a ring model
`timescale 1ns / 1ps

module tb_top
    import jos_pkg::*;
();

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] value;
        logic [LEFT_W-1:0]        left;
        logic                     last;
    } ring_outcome_t;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 64;
    localparam int PRINT_CAP    = 100;
    localparam int POOL_SIZE    = 8;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     start      = 1'b0;
    logic [REQ_W-1:0]         req_type   = REQ_APPEND;
    logic signed [DATA_W-1:0] item_value = '0;
    logic [STEP_W-1:0]        step_count = '0;
    logic                     busy;
    logic                     done;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] out_value;
    logic [LEFT_W-1:0]        entries_left;
    logic                     last_result;

    logic signed [DATA_W-1:0] ring_model[$];
    ring_outcome_t            outcome_q[$];
    logic signed [DATA_W-1:0] value_pool[POOL_SIZE];
    int                       err_count   = 0;
    int                       quiet_count = 0;
    int                       items_sent  = 0;
    bit                       gaps_on     = 1'b1;

    circular_list_josephus_eliminator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .item_value   (item_value),
        .step_count   (step_count),
        .done         (done),
        .status       (status),
        .out_value    (out_value),
        .entries_left (entries_left),
        .last_result  (last_result)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic flag_mismatch(input string what);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    // applies one request to the ring model and queues the results it causes
    function automatic void compute_ring_outcome(input logic [REQ_W-1:0] rt,
                                                 input logic signed [DATA_W-1:0] v,
                                                 input logic [STEP_W-1:0] s);
        ring_outcome_t            o;
        logic signed [DATA_W-1:0] kept[$];
        int                       cur;
        int                       pos;
        int                       step_i;
        o.status = ST_DONE;
        o.value  = '0;
        o.last   = 1'b1;
        step_i   = s;
        if (rt == REQ_APPEND)
        begin
            if (ring_model.size() >= DEPTH)
                o.status = ST_FULL;
            else
                ring_model.push_back(v);
            o.left = LEFT_W'(ring_model.size());
            outcome_q.push_back(o);
        end
        else if (rt == REQ_REMOVE)
        begin
            foreach (ring_model[i])
                if (ring_model[i] != v)
                    kept.push_back(ring_model[i]);
            ring_model = kept;
            o.left = LEFT_W'(ring_model.size());
            outcome_q.push_back(o);
        end
        else if (rt != REQ_ELIMINATE || step_i == 0 || ring_model.size() == 0)
        begin
            o.status = ST_NONE;
            o.left   = LEFT_W'(ring_model.size());
            outcome_q.push_back(o);
        end
        else
        begin
            cur = 0;
            while (ring_model.size() > 0)
            begin
                pos     = (cur + step_i - 1) % ring_model.size();
                o.value = ring_model[pos];
                ring_model.delete(pos);
                // counting resumes at the entry that slid into pos
                cur     = (ring_model.size() > 0) ? pos % ring_model.size() : 0;
                o.left  = LEFT_W'(ring_model.size());
                o.last  = (ring_model.size() == 0);
                outcome_q.push_back(o);
            end
        end
    endfunction

    task automatic idle_gap(input int n);
        @(negedge clk);
        start      <= 1'b0;
        req_type   <= REQ_W'($urandom);
        item_value <= $urandom;
        step_count <= STEP_W'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic send_req(input logic [REQ_W-1:0] rt,
                            input logic signed [DATA_W-1:0] v,
                            input logic [STEP_W-1:0] s);
        if (gaps_on && $urandom_range(0, 99) < 30)
            idle_gap($urandom_range(1, 18));
        @(negedge clk);
        start      <= 1'b1;
        req_type   <= rt;
        item_value <= v;
        step_count <= s;
        // transfer happens at the first edge with busy low
        do @(posedge clk); while (busy);
        compute_ring_outcome(rt, v, s);
        items_sent++;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 50)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return STEP_W'($urandom_range(1, 12));
        if (roll < 92)
            return STEP_W'($urandom_range(1, 65535));
        return '0;
    endfunction

    // mostly fill / remove / eliminate sequences, with some stray requests
    task automatic run_sequences(input int n_items);
        int stop_at;
        int target;
        int extra;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                target = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                                      : $urandom_range(9, DEPTH + 2);
                extra = target - ring_model.size();
                repeat (extra) send_req(REQ_APPEND, pick_value(), STEP_W'($urandom));
                if ($urandom_range(0, 99) < 50)
                    send_req(REQ_REMOVE, value_pool[$urandom_range(0, POOL_SIZE - 1)],
                             STEP_W'($urandom));
                if ($urandom_range(0, 99) < 20)
                    send_req(REQ_REMOVE, $urandom, STEP_W'($urandom));
                send_req(REQ_ELIMINATE, $urandom, pick_step());
            end
            else
                send_req(REQ_W'($urandom), $urandom, STEP_W'($urandom));
        end
    endtask

    task automatic test_directed_cases();
        send_req(REQ_ELIMINATE, '0, 16'd1);
        send_req(REQ_REMOVE, 32'sd7, '0);
        send_req(REQ_UNUSED, '0, 16'd3);
        send_req(REQ_APPEND, 32'h8000_0000, '0);
        send_req(REQ_APPEND, 32'h7fff_ffff, 16'hffff);
        send_req(REQ_APPEND, 32'h0000_0000, '0);
        send_req(REQ_APPEND, 32'hffff_ffff, '0);
        send_req(REQ_APPEND, 32'h0000_0000, '0);
        // duplicates go in one request, then a value that is not there
        send_req(REQ_REMOVE, 32'h0000_0000, '0);
        send_req(REQ_REMOVE, 32'sd5, '0);
        send_req(REQ_ELIMINATE, 32'sd9, 16'd0);
        send_req(REQ_UNUSED, '0, 16'd1);
        send_req(REQ_ELIMINATE, 32'hffff_ffff, 16'd1);
        send_req(REQ_APPEND, 32'sd11, '0);
        send_req(REQ_APPEND, 32'sd22, '0);
        send_req(REQ_APPEND, 32'sd33, '0);
        send_req(REQ_ELIMINATE, '0, 16'hffff);
        send_req(REQ_APPEND, 32'sd1, '0);
        send_req(REQ_APPEND, 32'sd2, '0);
        send_req(REQ_APPEND, 32'sd3, '0);
        send_req(REQ_APPEND, 32'sd4, '0);
        send_req(REQ_ELIMINATE, '0, 16'd2);
    endtask

    task automatic test_full_ring();
        while (ring_model.size() < DEPTH)
            send_req(REQ_APPEND, $urandom, STEP_W'($urandom));
        send_req(REQ_APPEND, $urandom, '0);
        send_req(REQ_ELIMINATE, '0, STEP_W'($urandom_range(1, 65535)));
        // full ring of few distinct values, so a remove takes many entries
        while (ring_model.size() < DEPTH)
            send_req(REQ_APPEND, value_pool[$urandom_range(0, 2)], '0);
        send_req(REQ_APPEND, value_pool[0], '0);
        send_req(REQ_REMOVE, value_pool[$urandom_range(0, 2)], '0);
        send_req(REQ_ELIMINATE, '0, STEP_W'($urandom_range(1, 5)));
    endtask

    task automatic test_random_sequences();
        run_sequences(265);
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        run_sequences(45);
    endtask

    always @(posedge clk)
    begin : check_results
        ring_outcome_t want;
        if (rst_n && done)
        begin
            if (outcome_q.size() == 0)
                flag_mismatch("result with nothing pending");
            else
            begin
                want = outcome_q.pop_front();
                if (status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
                if (out_value !== want.value)
                    flag_mismatch($sformatf("out_value %0d, want %0d", out_value, want.value));
                if (entries_left !== want.left)
                    flag_mismatch($sformatf("entries_left %0d, want %0d",
                                            entries_left, want.left));
                if (last_result !== want.last)
                    flag_mismatch($sformatf("last_result %0b, want %0b",
                                            last_result, want.last));
            end
        end
    end

    // counts cycles with neither a request transfer nor a result
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= STALL_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        for (int i = 2; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_full_ring();
        test_random_sequences();
        test_back_to_back();

        idle_gap(1);
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (outcome_q.size() != 0)
            flag_mismatch("results still pending at end");
        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ----- files.f -----
sv/jos_pkg.sv
sv/jos_cell.sv
sv/jos_mod.sv
sv/circular_list_josephus_eliminator.sv
tb/tb_top.sv
